// ===== rtl/nibdec_pkg.sv =====
// ----------------------------------------------------------------------------
// nibdec_pkg: shared types and constants of the ADPCM nibble decoder
// Holds the step table, the index moves, the rule codes and register indexes.
// ----------------------------------------------------------------------------
package nibdec_pkg;

  // Step table position range
  localparam int unsigned  STEP_POS_W = 6;
  localparam logic [5:0]   STEP_LAST  = 6'd48;

  // Step values
  localparam int unsigned  STEP_W     = 11;
  localparam logic [10:0]  STEP_MAX   = 11'd1552;
  localparam logic [10:0]  STEP_PATCH = 11'd1522;

  // History clamps
  localparam logic signed [31:0] HIST15_MAX = 32'sd16383;
  localparam logic signed [31:0] HIST15_MIN = -32'sd16384;
  localparam logic signed [31:0] HIST16_MAX = 32'sd32767;
  localparam logic signed [31:0] HIST16_MIN = -32'sd32768;

  // Configuration port
  localparam int unsigned  ADDR_W = 4;
  localparam logic [1:0]   REG_VARIANT    = 2'd0;
  localparam logic [1:0]   REG_PCFX_MODE  = 2'd1;
  localparam logic [1:0]   REG_START_HIST = 2'd2;
  localparam logic [1:0]   REG_START_IDX  = 2'd3;

  // Decode rules (code 3 decodes as the scaled rule)
  localparam logic [1:0]   VAR_SCALED = 2'd0;
  localparam logic [1:0]   VAR_MULT   = 2'd1;
  localparam logic [1:0]   VAR_SHIFT  = 2'd2;

  // Mode bits of the scaled rule
  localparam int unsigned  MODE_DOUBLE_STEP = 0;
  localparam logic [1:0]   MODE_RAW_OUT     = 2'd1;

  // Nibble fields
  localparam int unsigned  CODE_SIGN = 3;

  // Step table lookup; positions past the end read the last entry
  function automatic logic [10:0] step_lookup(input logic [5:0] pos);
    logic [10:0] v;
    case (pos)
      6'd0:  v = 11'd16;   6'd1:  v = 11'd17;   6'd2:  v = 11'd19;   6'd3:  v = 11'd21;
      6'd4:  v = 11'd23;   6'd5:  v = 11'd25;   6'd6:  v = 11'd28;   6'd7:  v = 11'd31;
      6'd8:  v = 11'd34;   6'd9:  v = 11'd37;   6'd10: v = 11'd41;   6'd11: v = 11'd45;
      6'd12: v = 11'd50;   6'd13: v = 11'd55;   6'd14: v = 11'd60;   6'd15: v = 11'd66;
      6'd16: v = 11'd73;   6'd17: v = 11'd80;   6'd18: v = 11'd88;   6'd19: v = 11'd97;
      6'd20: v = 11'd107;  6'd21: v = 11'd118;  6'd22: v = 11'd130;  6'd23: v = 11'd143;
      6'd24: v = 11'd157;  6'd25: v = 11'd173;  6'd26: v = 11'd190;  6'd27: v = 11'd209;
      6'd28: v = 11'd230;  6'd29: v = 11'd253;  6'd30: v = 11'd279;  6'd31: v = 11'd307;
      6'd32: v = 11'd337;  6'd33: v = 11'd371;  6'd34: v = 11'd408;  6'd35: v = 11'd449;
      6'd36: v = 11'd494;  6'd37: v = 11'd544;  6'd38: v = 11'd598;  6'd39: v = 11'd658;
      6'd40: v = 11'd724;  6'd41: v = 11'd796;  6'd42: v = 11'd876;  6'd43: v = 11'd963;
      6'd44: v = 11'd1060; 6'd45: v = 11'd1166; 6'd46: v = 11'd1282; 6'd47: v = 11'd1411;
      default: v = STEP_MAX;
    endcase
    return v;
  endfunction

  // Next step position: down one for small magnitudes, up 2..8 otherwise, saturated
  function automatic logic [5:0] step_move(input logic [5:0] pos, input logic [2:0] mag);
    logic [6:0] up;
    logic [5:0] res;
    up = {1'b0, pos} + {3'b000, mag - 3'd3, 1'b0};
    if (!mag[2]) begin
      res = (pos == 6'd0) ? 6'd0 : pos - 6'd1;
    end else if (up > {1'b0, STEP_LAST}) begin
      res = STEP_LAST;
    end else begin
      res = up[5:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/oki_adpcm_nibble_decoder.sv =====
// ----------------------------------------------------------------------------
// oki_adpcm_nibble_decoder: 4-bit ADPCM code to 16-bit PCM sample
// One code per transfer, one sample per transfer. Predictor and step
// position update in the cycle the code is taken; a skid stage holds a
// sample while the output side stalls.
// ----------------------------------------------------------------------------
// Output: the sample is registered on the code transfer, or held in the skid register while the output stalls.
// Throughput: one code per cycle while in_stall is low, set by the combinational
//   predictor/step recurrence (one 11x5 multiply, a 32-bit add and, but for the multiply rule, a clamp).
// in_stall rises only when both the output and the skid register are full.
// Reset (rst, synchronous): clears history, step position, configuration registers, valids.
// ----------------------------------------------------------------------------
module oki_adpcm_nibble_decoder
  import nibdec_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // code channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [3:0]        code,
  input  logic              restart,
  // sample channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [15:0] sample,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Configuration registers
  logic [1:0]        variant;
  logic [1:0]        pcfx_mode;
  logic signed [15:0] start_history;
  logic [5:0]        start_step_index;

  // Decoder state
  logic signed [31:0] history;
  logic [5:0]         step_pos;

  // Skid stage
  logic               skid_valid;
  logic signed [15:0] skid_sample;

  // Datapath
  logic               accept;
  logic               out_take;
  logic signed [31:0] hist_base;
  logic [5:0]         pos_base;
  logic [2:0]         mag;
  logic [10:0]        step_val;
  logic [10:0]        step_x;
  logic [4:0]         mult;
  logic [15:0]        prod;
  logic [15:0]        delta_mag;
  logic signed [31:0] hist_sum;
  logic signed [31:0] history_next;
  logic [5:0]         step_pos_next;
  logic signed [15:0] sample_next;

  assign pready   = 1'b1;
  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign out_take = out_valid && !out_stall;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      variant          <= VAR_SCALED;
      pcfx_mode        <= 2'd0;
      start_history    <= 16'sd0;
      start_step_index <= 6'd0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_VARIANT:    variant          <= pwdata[1:0];
        REG_PCFX_MODE:  pcfx_mode        <= pwdata[1:0];
        REG_START_HIST: start_history    <= pwdata[15:0];
        REG_START_IDX:  start_step_index <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (paddr[3:2])
      REG_VARIANT:    prdata = {30'd0, variant};
      REG_PCFX_MODE:  prdata = {30'd0, pcfx_mode};
      REG_START_HIST: prdata = {16'd0, start_history};
      REG_START_IDX:  prdata = {26'd0, start_step_index};
      default:        prdata = 32'd0;
    endcase
  end

  // Starting point: live state or reload from registers
  always_comb begin
    if (restart) begin
      hist_base = 32'(start_history);
      pos_base  = (start_step_index > STEP_LAST) ? STEP_LAST : start_step_index;
    end else begin
      hist_base = history;
      pos_base  = step_pos;
    end
  end

  // Delta magnitude: one small multiply covers all rules
  always_comb begin
    mag      = code[2:0];
    step_val = step_lookup(pos_base);
    step_x   = step_val;
    case (variant)
      VAR_MULT:  mult = {1'b0, mag, 1'b1};
      VAR_SHIFT: mult = {mag, 1'b1, 1'b0};
      default: begin
        if (pcfx_mode[MODE_DOUBLE_STEP]) begin
          if (step_val == STEP_MAX) step_x = STEP_PATCH;
          mult = {({1'b0, mag} + 4'd1), 1'b0};
        end else begin
          mult = {1'b0, ({1'b0, mag} + 4'd1)};
        end
      end
    endcase
    prod      = {5'd0, step_x} * {11'd0, mult};
    delta_mag = (variant == VAR_MULT) ? {3'd0, prod[15:3]} : prod;
  end

  // History update, clamp and sample
  always_comb begin
    if (code[CODE_SIGN]) begin
      hist_sum = hist_base - $signed({16'd0, delta_mag});
    end else begin
      hist_sum = hist_base + $signed({16'd0, delta_mag});
    end
    case (variant)
      VAR_MULT: begin
        history_next = hist_sum;
        sample_next  = hist_sum[15:0];
      end
      VAR_SHIFT: begin
        if (hist_sum > HIST16_MAX)      history_next = HIST16_MAX;
        else if (hist_sum < HIST16_MIN) history_next = HIST16_MIN;
        else                            history_next = hist_sum;
        sample_next = history_next[15:0];
      end
      default: begin
        if (hist_sum > HIST15_MAX)      history_next = HIST15_MAX;
        else if (hist_sum < HIST15_MIN) history_next = HIST15_MIN;
        else                            history_next = hist_sum;
        sample_next = (pcfx_mode == MODE_RAW_OUT) ? history_next[15:0]
                                                  : {history_next[14:0], 1'b0};
      end
    endcase
    step_pos_next = step_move(pos_base, mag);
  end

  // State update on each code transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      history  <= 32'sd0;
      step_pos <= 6'd0;
    end else if (accept) begin
      history  <= history_next;
      step_pos <= step_pos_next;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        sample     <= skid_sample;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && out_stall) begin
        skid_sample <= sample_next;
        skid_valid  <= 1'b1;
      end else begin
        sample    <= sample_next;
        out_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // Checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a sample while the output is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid filled without an output stall");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step_pos <= STEP_LAST)
    else $error("step position past the table end");

  a_shift_clamp: assert property (@(posedge clk) disable iff (rst)
    (accept && variant == VAR_SHIFT) |=>
      (history <= HIST16_MAX && history >= HIST16_MIN))
    else $error("history outside 16-bit range after shift-add decode");

endmodule
